FILE: rtl/missing_wedge_fourier_mask_defines.svh
// ----------------------------------------------------------------------------
// Missing wedge mask assertion macros
// Concurrent check helpers shared by the mask datapath modules.
// ----------------------------------------------------------------------------
`ifndef MISSING_WEDGE_FOURIER_MASK_DEFINES_SVH
`define MISSING_WEDGE_FOURIER_MASK_DEFINES_SVH

// Check cons in the same cycle as ante.
`define MWFM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check cons in the cycle after ante.
`define MWFM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/mwfm_pkg.sv
// ----------------------------------------------------------------------------
// Missing wedge mask package
// Shared widths, register codes, configuration and item types.
// ----------------------------------------------------------------------------
`default_nettype none

package mwfm_pkg;

   localparam int MAX_SIZE_DEFAULT = 1024;
   localparam int QUEUE_DEPTH      = 4;
   localparam int SIZE_W           = 11;
   localparam int DATA_W           = 32;
   localparam int COEF_W           = 32;
   localparam int CSR_DATA_W       = 32;
   localparam int CSR_ADDR_W       = 5;
   localparam int REG_IDX_W        = 3;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_SIZE_X  = 3'd0,
      REG_SIZE_Y  = 3'd1,
      REG_SIZE_Z  = 3'd2,
      REG_COEF_Z  = 3'd3,
      REG_COEF_Y  = 3'd4,
      REG_TAN_MIN = 3'd5,
      REG_TAN_MAX = 3'd6
   } reg_index_type;

   localparam logic signed [COEF_W-1:0] TAN_NO_MIN    = 32'sh8000_0000;
   localparam logic signed [COEF_W-1:0] TAN_NO_MAX    = 32'sh7FFF_FFFF;
   localparam logic signed [COEF_W-1:0] COEF_Z_RESET  = 32'sh0100_0000;
   localparam logic signed [COEF_W-1:0] COEF_Y_RESET  = 32'sh0000_0000;
   localparam logic [SIZE_W-1:0]        SIZE_RESET    = 11'd1;

   // Voxel class, decided from the frequencies alone.
   typedef enum logic [1:0] {
      KIND_ORIGIN    = 2'd0,
      KIND_AXIS_Z    = 2'd1,
      KIND_AXIS_FLAT = 2'd2,
      KIND_GENERAL   = 2'd3
   } kind_type;

   typedef struct packed {
      logic [SIZE_W-1:0]        size_x;
      logic [SIZE_W-1:0]        size_y;
      logic [SIZE_W-1:0]        size_z;
      logic signed [COEF_W-1:0] coef_z;
      logic signed [COEF_W-1:0] coef_y;
      logic signed [COEF_W-1:0] tan_min;
      logic signed [COEF_W-1:0] tan_max;
   } cfg_type;

   typedef struct packed {
      kind_type          kind;
      logic              volume_end;
      logic [DATA_W-1:0] real_bits;
      logic [DATA_W-1:0] imag_bits;
   } item_type;

endpackage

`default_nettype wire

FILE: rtl/mwfm_req_if.sv
// ----------------------------------------------------------------------------
// Voxel request channel
// Valid/ready channel carrying one complex voxel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwfm_req_if;
   import mwfm_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] real_bits;
   logic [DATA_W-1:0] imag_bits;

   modport source (output valid, output real_bits, output imag_bits, input ready);
   modport sink   (input valid, input real_bits, input imag_bits, output ready);
endinterface

`default_nettype wire

FILE: rtl/mwfm_rsp_if.sv
// ----------------------------------------------------------------------------
// Voxel response channel
// Valid/ready channel carrying one masked voxel per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface mwfm_rsp_if;
   import mwfm_pkg::*;

   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] real_out;
   logic [DATA_W-1:0] imag_out;
   logic              masked;
   logic              volume_end;

   modport source (output valid, output real_out, output imag_out, output masked,
                   output volume_end, input ready);
   modport sink   (input valid, input real_out, input imag_out, input masked,
                   input volume_end, output ready);
endinterface

`default_nettype wire

FILE: rtl/mwfm_csr.sv
// ----------------------------------------------------------------------------
// Missing wedge mask register file
// APB-style write/read port holding volume sizes, coefficients and tangents.
// ----------------------------------------------------------------------------
`default_nettype none

module mwfm_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mwfm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mwfm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mwfm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready,
   output mwfm_pkg::cfg_type               cfg
);
   import mwfm_pkg::*;

   cfg_type       cfg_ff;
   reg_index_type reg_idx;
   logic          wr_en;

   assign reg_idx = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.size_x  <= SIZE_RESET;
         cfg_ff.size_y  <= SIZE_RESET;
         cfg_ff.size_z  <= SIZE_RESET;
         cfg_ff.coef_z  <= COEF_Z_RESET;
         cfg_ff.coef_y  <= COEF_Y_RESET;
         cfg_ff.tan_min <= TAN_NO_MIN;
         cfg_ff.tan_max <= TAN_NO_MAX;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_SIZE_X:  cfg_ff.size_x  <= pwdata[SIZE_W-1:0];
            REG_SIZE_Y:  cfg_ff.size_y  <= pwdata[SIZE_W-1:0];
            REG_SIZE_Z:  cfg_ff.size_z  <= pwdata[SIZE_W-1:0];
            REG_COEF_Z:  cfg_ff.coef_z  <= $signed(pwdata);
            REG_COEF_Y:  cfg_ff.coef_y  <= $signed(pwdata);
            REG_TAN_MIN: cfg_ff.tan_min <= $signed(pwdata);
            REG_TAN_MAX: cfg_ff.tan_max <= $signed(pwdata);
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SIZE_X:  prdata = CSR_DATA_W'(cfg_ff.size_x);
         REG_SIZE_Y:  prdata = CSR_DATA_W'(cfg_ff.size_y);
         REG_SIZE_Z:  prdata = CSR_DATA_W'(cfg_ff.size_z);
         REG_COEF_Z:  prdata = cfg_ff.coef_z;
         REG_COEF_Y:  prdata = cfg_ff.coef_y;
         REG_TAN_MIN: prdata = cfg_ff.tan_min;
         REG_TAN_MAX: prdata = cfg_ff.tan_max;
         default:     prdata = '0;
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/mwfm_front.sv
// ----------------------------------------------------------------------------
// Missing wedge mask front end
// Accepts voxels, walks the x/y/z counters and classifies each voxel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "missing_wedge_fourier_mask_defines.svh"

module mwfm_front #(
   parameter int MAX_SIZE = mwfm_pkg::MAX_SIZE_DEFAULT,
   parameter int FW       = $clog2(MAX_SIZE) + 2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mwfm_pkg::cfg_type     cfg,
   mwfm_req_if.sink              req_chan,
   input  logic                  q_full,
   output logic                  push,
   output mwfm_pkg::item_type    item,
   output logic signed [FW-1:0]  fx,
   output logic signed [FW-1:0]  fy,
   output logic signed [FW-1:0]  fz
);
   import mwfm_pkg::*;

   localparam int IW = $clog2(MAX_SIZE);
   localparam int SW = IW + 1;
   localparam int CW = (SW > SIZE_W) ? SW : SIZE_W;

   function automatic logic [SW-1:0] eff_size(input logic [SIZE_W-1:0] s);
      logic [CW-1:0] w;
      w = CW'(s);
      if (w == '0) begin
         return SW'(1);
      end else if (w > CW'(MAX_SIZE)) begin
         return SW'(MAX_SIZE);
      end
      return SW'(w);
   endfunction

   // Upper half of the index range stands for negative frequencies.
   function automatic logic signed [FW-1:0] freq(input logic [IW-1:0] idx,
                                                 input logic [SW-1:0] s);
      logic [SW-1:0] half;
      half = (s - SW'(1)) >> 1;
      if ({1'b0, idx} > half) begin
         return $signed({2'b00, idx}) - $signed({1'b0, s});
      end
      return $signed({2'b00, idx});
   endfunction

   logic [IW-1:0] x_ff, y_ff, z_ff;
   logic [IW-1:0] x_in, y_in, z_in;
   logic [SW-1:0] sx, sy, sz;
   logic          x_wrap, y_wrap, z_wrap;
   logic          accept;

   assign sx = eff_size(cfg.size_x);
   assign sy = eff_size(cfg.size_y);
   assign sz = eff_size(cfg.size_z);

   assign x_wrap = ({1'b0, x_ff} + SW'(1)) >= sx;
   assign y_wrap = ({1'b0, y_ff} + SW'(1)) >= sy;
   assign z_wrap = ({1'b0, z_ff} + SW'(1)) >= sz;

   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && !q_full;
   assign push           = accept;

   assign fx = freq(x_ff, sx);
   assign fy = freq(y_ff, sy);
   assign fz = freq(z_ff, sz);

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      if (accept) begin
         x_in = x_wrap ? '0 : x_ff + IW'(1);
         if (x_wrap) begin
            y_in = y_wrap ? '0 : y_ff + IW'(1);
            if (y_wrap) begin
               z_in = z_wrap ? '0 : z_ff + IW'(1);
            end
         end
      end
   end

   always_comb begin
      item.real_bits  = req_chan.real_bits;
      item.imag_bits  = req_chan.imag_bits;
      item.volume_end = x_wrap && y_wrap && z_wrap;
      if (fx == '0 && fy == '0 && fz == '0) begin
         item.kind = KIND_ORIGIN;
      end else if (fx == '0 && fz != '0) begin
         item.kind = KIND_AXIS_Z;
      end else if (fx == '0) begin
         item.kind = KIND_AXIS_FLAT;
      end else begin
         item.kind = KIND_GENERAL;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
         y_ff <= '0;
         z_ff <= '0;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   `MWFM_ASSERT_NEXT(a_end_wraps_all, clock, reset, accept && item.volume_end, x_ff == '0 && y_ff == '0 && z_ff == '0, "counters not at origin after volume end")

endmodule

`default_nettype wire

FILE: rtl/mwfm_queue.sv
// ----------------------------------------------------------------------------
// Missing wedge mask item queue
// Short register FIFO between the front end and the arithmetic back end.
// ----------------------------------------------------------------------------
`default_nettype none
`include "missing_wedge_fourier_mask_defines.svh"

module mwfm_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = mwfm_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             pop_valid,
   output logic [WIDTH-1:0] pop_data
);
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW-1:0]    wr_ptr_in, rd_ptr_in;
   logic [NW-1:0]    count_ff, count_in;

   assign full      = count_ff == NW'(DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `MWFM_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= NW'(DEPTH), "queue count beyond depth")
   `MWFM_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + NW'(1), "queue count did not rise on push")
   `MWFM_ASSERT_NOW(a_no_pop_empty, clock, reset, pop, pop_valid, "pop from empty queue")

endmodule

`default_nettype wire

FILE: rtl/mwfm_back.sv
// ----------------------------------------------------------------------------
// Missing wedge mask back end
// Three-stage multiply, sum and compare pipeline ending in the output register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "missing_wedge_fourier_mask_defines.svh"

module mwfm_back #(
   parameter int FW = $clog2(mwfm_pkg::MAX_SIZE_DEFAULT) + 2
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mwfm_pkg::cfg_type    cfg,
   input  logic                 q_valid,
   input  mwfm_pkg::item_type   q_item,
   input  logic signed [FW-1:0] q_fx,
   input  logic signed [FW-1:0] q_fy,
   input  logic signed [FW-1:0] q_fz,
   output logic                 q_pop,
   mwfm_rsp_if.source           rsp_chan
);
   import mwfm_pkg::*;

   localparam int PW   = FW + COEF_W;
   localparam int NW   = PW + 1;
   localparam int CMPW = PW + 8;

   // Stage 1: products
   logic                 v1_ff;
   item_type             item1_ff;
   logic                 neg1_ff;
   logic signed [PW-1:0] pz1_ff, py1_ff, ph1_ff, pl1_ff;
   // Stage 2: numerator and scaled limits
   logic                   v2_ff;
   item_type               item2_ff;
   logic                   neg2_ff;
   logic signed [NW-1:0]   n2_ff;
   logic signed [CMPW-1:0] hi2_ff, lo2_ff;
   // Stage 3: output register
   logic              v3_ff;
   logic [DATA_W-1:0] real3_ff, imag3_ff;
   logic              mask3_ff, end3_ff;

   logic s1_ready, s2_ready, s3_ready;
   logic no_max, no_min;
   logic signed [CMPW-1:0] n_ext;
   logic above, below, mask_in;

   assign s3_ready = !v3_ff || rsp_chan.ready;
   assign s2_ready = !v2_ff || s3_ready;
   assign s1_ready = !v1_ff || s2_ready;
   assign q_pop    = q_valid && s1_ready;

   assign no_max = cfg.tan_max == TAN_NO_MAX;
   assign no_min = cfg.tan_min == TAN_NO_MIN;

   assign n_ext = CMPW'(n2_ff);
   assign above = neg2_ff ? (n_ext < hi2_ff) : (n_ext > hi2_ff);
   assign below = neg2_ff ? (n_ext > lo2_ff) : (n_ext < lo2_ff);

   always_comb begin
      unique case (item2_ff.kind)
         KIND_ORIGIN:    mask_in = 1'b0;
         KIND_AXIS_Z:    mask_in = !no_max;
         KIND_AXIS_FLAT: mask_in = (!no_max && cfg.tan_max < 0) ||
                                   (!no_min && cfg.tan_min > 0);
         KIND_GENERAL:   mask_in = (!no_max && above) || (!no_min && below);
         default:        mask_in = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (s1_ready) begin
            v1_ff <= q_valid;
         end
         if (s2_ready) begin
            v2_ff <= v1_ff;
         end
         if (s3_ready) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         item1_ff <= q_item;
         neg1_ff  <= q_fx < 0;
         pz1_ff   <= PW'(q_fz) * PW'($signed(cfg.coef_z));
         py1_ff   <= PW'(q_fy) * PW'($signed(cfg.coef_y));
         ph1_ff   <= PW'(q_fx) * PW'($signed(cfg.tan_max));
         pl1_ff   <= PW'(q_fx) * PW'($signed(cfg.tan_min));
      end
      if (s2_ready) begin
         item2_ff <= item1_ff;
         neg2_ff  <= neg1_ff;
         n2_ff    <= NW'(pz1_ff) + NW'(py1_ff);
         // Align Q16.16 tangent with Q8.24 coefficients.
         hi2_ff   <= CMPW'(ph1_ff) <<< 8;
         lo2_ff   <= CMPW'(pl1_ff) <<< 8;
      end
      if (s3_ready) begin
         real3_ff <= mask_in ? '0 : item2_ff.real_bits;
         imag3_ff <= mask_in ? '0 : item2_ff.imag_bits;
         mask3_ff <= mask_in;
         end3_ff  <= item2_ff.volume_end;
      end
   end

   assign rsp_chan.valid      = v3_ff;
   assign rsp_chan.real_out   = real3_ff;
   assign rsp_chan.imag_out   = imag3_ff;
   assign rsp_chan.masked     = mask3_ff;
   assign rsp_chan.volume_end = end3_ff;

   `MWFM_ASSERT_NEXT(a_origin_kept, clock, reset, v2_ff && s3_ready && item2_ff.kind == KIND_ORIGIN, !rsp_chan.masked, "origin voxel masked")
   `MWFM_ASSERT_NOW(a_masked_zero, clock, reset, v3_ff && mask3_ff, real3_ff == '0 && imag3_ff == '0, "masked voxel carries data")

endmodule

`default_nettype wire

FILE: rtl/missing_wedge_fourier_mask.sv
// ----------------------------------------------------------------------------
// Missing wedge Fourier mask
// Path: a voxel transferred in is written to the queue, then passes the product, sum and output registers.
// Throughput: one voxel per cycle while the response side is ready, set by the three-stage back-end pipeline.
// The four-entry queue keeps the request side moving while a response stalls.
// Reset: counters to zero, registers to defaults, queue and pipeline emptied.
// ----------------------------------------------------------------------------
`default_nettype none

module missing_wedge_fourier_mask #(
   parameter int MAX_SIZE    = mwfm_pkg::MAX_SIZE_DEFAULT,
   parameter int QUEUE_DEPTH = mwfm_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   mwfm_req_if.sink                        req_chan,
   mwfm_rsp_if.source                      rsp_chan,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mwfm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mwfm_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [mwfm_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import mwfm_pkg::*;

   localparam int FW = $clog2(MAX_SIZE) + 2;
   localparam int QW = $bits(item_type) + 3 * FW;

   cfg_type              cfg;
   logic                 push, q_full, q_valid, q_pop;
   item_type             f_item, q_item;
   logic signed [FW-1:0] f_fx, f_fy, f_fz;
   logic signed [FW-1:0] q_fx, q_fy, q_fz;
   logic [QW-1:0]        q_in_data, q_out_data;

   mwfm_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   mwfm_front #(
      .MAX_SIZE (MAX_SIZE),
      .FW       (FW)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .req_chan (req_chan),
      .q_full   (q_full),
      .push     (push),
      .item     (f_item),
      .fx       (f_fx),
      .fy       (f_fy),
      .fz       (f_fz)
   );

   assign q_in_data = {f_item, f_fx, f_fy, f_fz};
   assign {q_item, q_fx, q_fy, q_fz} = q_out_data;

   mwfm_queue #(
      .WIDTH (QW),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_out_data)
   );

   mwfm_back #(
      .FW (FW)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_fx     (q_fx),
      .q_fy     (q_fy),
      .q_fz     (q_fz),
      .q_pop    (q_pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

FILE: tb/sv/mwfm_wedge_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Missing wedge mask checker
// Watches the voxel and register ports, keeps its own copy of the counters
// and registers, predicts each masked voxel and compares the responses in
// order. Hands its failure and progress counts to the testbench top.
// ----------------------------------------------------------------------------
module mwfm_wedge_checker (
   input  logic                            clock,
   input  logic                            reset,
   mwfm_req_if                             req_mon,
   mwfm_rsp_if                             rsp_mon,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic                            pready,
   input  logic [mwfm_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [mwfm_pkg::CSR_DATA_W-1:0] pwdata,
   output int                              mismatches,
   output int                              results_seen,
   output int                              masked_seen,
   output int                              volumes_seen
);
   import mwfm_pkg::*;

   typedef struct packed {
      logic [DATA_W-1:0] real_out;
      logic [DATA_W-1:0] imag_out;
      logic              masked;
      logic              volume_end;
   } voxel_result_type;

   cfg_type          wedge_cfg;
   int               x_pos, y_pos, z_pos;
   int               fail_count, result_count, masked_count, end_count;
   voxel_result_type voxels_in_flight[$];

   // Register value as the counters use it: zero acts as one, clamp to the maximum.
   function automatic int extent(logic [SIZE_W-1:0] s);
      if (s == '0)
         return 1;
      if (s > MAX_SIZE_DEFAULT)
         return MAX_SIZE_DEFAULT;
      return int'(s);
   endfunction

   // Upper half of the index range stands for negative frequencies.
   function automatic longint centered(int idx, int s);
      if (idx > (s - 1) / 2)
         return longint'(idx - s);
      return longint'(idx);
   endfunction

   function automatic logic in_wedge(cfg_type c, longint fx, longint fy, longint fz);
      longint cz, cy, tmin, tmax, n, hi, lo;
      logic   no_min, no_max, above, below;
      cz     = $signed(c.coef_z);
      cy     = $signed(c.coef_y);
      tmin   = $signed(c.tan_min);
      tmax   = $signed(c.tan_max);
      no_min = (c.tan_min == TAN_NO_MIN);
      no_max = (c.tan_max == TAN_NO_MAX);
      if (fx == 0 && fy == 0 && fz == 0)
         return 1'b0;
      if (fx == 0) begin
         // straight up the z axis is 90 degrees, flat in y is 0 degrees
         if (fz != 0)
            return !no_max;
         return (!no_max && tmax < 0) || (!no_min && tmin > 0);
      end
      // compare n/(fx*2^24) against tan/2^16 without dividing
      n  = fz * cz + fy * cy;
      hi = tmax * 256 * fx;
      lo = tmin * 256 * fx;
      if (fx > 0) begin
         above = n > hi;
         below = n < lo;
      end else begin
         above = n < hi;
         below = n > lo;
      end
      return (!no_max && above) || (!no_min && below);
   endfunction

   always @(posedge clock) begin : track
      voxel_result_type want, got;
      int               sx, sy, sz;
      logic             carry;
      if (reset) begin
         wedge_cfg = '{size_x: SIZE_RESET, size_y: SIZE_RESET, size_z: SIZE_RESET,
                       coef_z: COEF_Z_RESET, coef_y: COEF_Y_RESET,
                       tan_min: TAN_NO_MIN, tan_max: TAN_NO_MAX};
         x_pos = 0;
         y_pos = 0;
         z_pos = 0;
         voxels_in_flight.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (reg_index_type'(paddr[CSR_ADDR_W-1:2]))
               REG_SIZE_X:  wedge_cfg.size_x  = pwdata[SIZE_W-1:0];
               REG_SIZE_Y:  wedge_cfg.size_y  = pwdata[SIZE_W-1:0];
               REG_SIZE_Z:  wedge_cfg.size_z  = pwdata[SIZE_W-1:0];
               REG_COEF_Z:  wedge_cfg.coef_z  = pwdata;
               REG_COEF_Y:  wedge_cfg.coef_y  = pwdata;
               REG_TAN_MIN: wedge_cfg.tan_min = pwdata;
               REG_TAN_MAX: wedge_cfg.tan_max = pwdata;
               default: ;
            endcase
         end

         if (req_mon.valid && req_mon.ready) begin
            sx = extent(wedge_cfg.size_x);
            sy = extent(wedge_cfg.size_y);
            sz = extent(wedge_cfg.size_z);
            want.masked   = in_wedge(wedge_cfg, centered(x_pos, sx), centered(y_pos, sy),
                                     centered(z_pos, sz));
            want.real_out = want.masked ? '0 : req_mon.real_bits;
            want.imag_out = want.masked ? '0 : req_mon.imag_bits;
            // a counter at its last index or past it wraps on this step and carries
            carry = (x_pos + 1 >= sx);
            x_pos = carry ? 0 : x_pos + 1;
            if (carry) begin
               carry = (y_pos + 1 >= sy);
               y_pos = carry ? 0 : y_pos + 1;
            end
            if (carry) begin
               carry = (z_pos + 1 >= sz);
               z_pos = carry ? 0 : z_pos + 1;
            end
            want.volume_end = carry;
            voxels_in_flight.push_back(want);
            if (want.masked)
               masked_count++;
            if (want.volume_end)
               end_count++;
         end

         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{real_out: rsp_mon.real_out, imag_out: rsp_mon.imag_out,
                    masked: rsp_mon.masked, volume_end: rsp_mon.volume_end};
            result_count++;
            if (voxels_in_flight.size() == 0) begin
               fail_count++;
               $display("%0t unexpected voxel: expected none, got re %h im %h masked %b end %b",
                        $time, got.real_out, got.imag_out, got.masked, got.volume_end);
            end else begin
               want = voxels_in_flight.pop_front();
               if (got.real_out !== want.real_out || got.imag_out !== want.imag_out ||
                   got.masked !== want.masked || got.volume_end !== want.volume_end) begin
                  fail_count++;
                  $display("%0t voxel %0d: expected %h %h %b %b, got %h %h %b %b",
                           $time, result_count, want.real_out, want.imag_out,
                           want.masked, want.volume_end, got.real_out, got.imag_out,
                           got.masked, got.volume_end);
               end
            end
         end
      end
      mismatches   <= fail_count;
      results_seen <= result_count;
      masked_seen  <= masked_count;
      volumes_seen <= end_count;
   end

endmodule

FILE: tb/sv/missing_wedge_fourier_mask_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Missing wedge mask testbench
// Directed voxels over the special angles and size corners, then random
// register settings and voxel bursts under rotating idle and stall mixes,
// one long response hold-off. The checker predicts and compares.
// ----------------------------------------------------------------------------
module missing_wedge_fourier_mask_tb;
   import mwfm_pkg::*;

   localparam int VOXEL_TARGET = 1900;
   // longest quiet stretch in a good run is the response hold-off plus random
   // stalling; allow several times that
   localparam int LONG_HOLD    = 300;
   localparam int QUIET_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 12;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  psel, penable, pwrite, pready;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata, prdata;

   mwfm_req_if req_chan ();
   mwfm_rsp_if rsp_chan ();

   int voxels_sent  = 0;
   int idle_pct     = 0;
   int stall_pct    = 0;
   int hold_asked   = 0;
   int hold_taken   = 0;
   int hold_left    = 0;
   int quiet_cycles = 0;
   int mismatches, results_seen, masked_seen, volumes_seen;

   always #2 clock = ~clock;

   missing_wedge_fourier_mask i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   mwfm_wedge_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req_mon      (req_chan),
      .rsp_mon      (rsp_chan),
      .psel         (psel),
      .penable      (penable),
      .pwrite       (pwrite),
      .pready       (pready),
      .paddr        (paddr),
      .pwdata       (pwdata),
      .mismatches   (mismatches),
      .results_seen (results_seen),
      .masked_seen  (masked_seen),
      .volumes_seen (volumes_seen)
   );

   // Response side: random stalls, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= hold_left - 1;
      end else if (hold_taken != hold_asked) begin
         rsp_chan.ready <= 1'b0;
         hold_left      <= LONG_HOLD;
         hold_taken     <= hold_asked;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t watchdog: no transfer for %0d cycles", $time, quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic logic [DATA_W-1:0] rand_word();
      case ($urandom_range(7))
         0:       return '0;
         1:       return '1;
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] rand_coef();
      case ($urandom_range(5))
         0: return $urandom();
         1: begin
            case ($urandom_range(2))
               0:       return 32'h8000_0000;
               1:       return 32'h7FFF_FFFF;
               default: return '0;
            endcase
         end
         default: return $urandom_range(8 << 24) - (4 << 24);
      endcase
   endfunction

   function automatic logic [COEF_W-1:0] rand_tan(logic [COEF_W-1:0] open_end);
      case ($urandom_range(5))
         0: return open_end;
         1: return $urandom();
         2: begin
            case ($urandom_range(5))
               0:       return TAN_NO_MIN;
               1:       return TAN_NO_MAX;
               2:       return 32'h8000_0001;
               3:       return 32'h7FFF_FFFE;
               4:       return '1;
               default: return '0;
            endcase
         end
         default: return $urandom_range(16 << 16) - (8 << 16);
      endcase
   endfunction

   // Setup and access phases, then idle so writes never share a step.
   task automatic csr_write(input reg_index_type idx, input logic [CSR_DATA_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Size registers get random upper bits; only the low eleven count.
   task automatic write_size(input reg_index_type idx, input logic [SIZE_W-1:0] extent);
      logic [CSR_DATA_W-1:0] w;
      w             = $urandom();
      w[SIZE_W-1:0] = extent;
      csr_write(idx, w);
   endtask

   task automatic send_voxel(input logic [DATA_W-1:0] re, input logic [DATA_W-1:0] im);
      while ($urandom_range(99) < idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.real_bits <= re;
      req_chan.imag_bits <= im;
      do @(posedge clock); while (!req_chan.ready);
      voxels_sent++;
   endtask

   // Drop valid and hold the sender until every voxel has come back.
   task automatic drain_voxels();
      req_chan.valid <= 1'b0;
      while (results_seen != voxels_sent)
         @(posedge clock);
   endtask

   task automatic pick_setup();
      reg_index_type     size_regs [3];
      logic [SIZE_W-1:0] extent [3];
      size_regs = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z};
      for (int d = 0; d < 3; d++)
         extent[d] = SIZE_W'($urandom_range(6, 1));
      case ($urandom_range(9))
         0: extent[$urandom_range(2)] = SIZE_W'($urandom_range(MAX_SIZE_DEFAULT, 64));
         1: begin
            case ($urandom_range(2))
               0:       extent[$urandom_range(2)] = '0;
               1:       extent[$urandom_range(2)] = SIZE_W'(MAX_SIZE_DEFAULT);
               default: extent[$urandom_range(2)] =
                           SIZE_W'($urandom_range(2047, MAX_SIZE_DEFAULT + 1));
            endcase
         end
         default: ;
      endcase
      for (int d = 0; d < 3; d++)
         if ($urandom_range(3) != 0)
            write_size(size_regs[d], extent[d]);
      if ($urandom_range(3) != 0)
         csr_write(REG_COEF_Z, rand_coef());
      if ($urandom_range(3) != 0)
         csr_write(REG_COEF_Y, rand_coef());
      if ($urandom_range(3) != 0)
         csr_write(REG_TAN_MIN, rand_tan(TAN_NO_MIN));
      if ($urandom_range(3) != 0)
         csr_write(REG_TAN_MAX, rand_tan(TAN_NO_MAX));
   endtask

   initial begin : stimulus
      int directed_sent, phases, burst;
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_chan.valid     = 1'b0;
      req_chan.real_bits = '0;
      req_chan.imag_bits = '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // registers at reset: one-voxel volumes, every voxel is the origin
      send_voxel('0, '1);
      send_voxel('1, '0);
      drain_voxels();

      // 2x2x2 with +-45 degree limits: origin, flat, vertical, general, boundary
      write_size(REG_SIZE_X, 2);
      write_size(REG_SIZE_Y, 2);
      write_size(REG_SIZE_Z, 2);
      csr_write(REG_COEF_Z, 32'h0100_0000);
      csr_write(REG_COEF_Y, 32'h0100_0000);
      csr_write(REG_TAN_MIN, -(32'sd1 <<< 16));
      csr_write(REG_TAN_MAX, 32'sd1 <<< 16);
      repeat (8) send_voxel(rand_word(), rand_word());
      drain_voxels();

      // zero x size, positive lower limit, no upper limit
      write_size(REG_SIZE_X, 0);
      csr_write(REG_TAN_MIN, 32'sd2 <<< 16);
      csr_write(REG_TAN_MAX, TAN_NO_MAX);
      repeat (4) send_voxel(rand_word(), rand_word());
      drain_voxels();

      // oversized x, extreme coefficients, then shrink x mid-row past the index
      write_size(REG_SIZE_X, 2000);
      csr_write(REG_COEF_Z, 32'h8000_0000);
      csr_write(REG_COEF_Y, 32'h7FFF_FFFF);
      csr_write(REG_TAN_MIN, TAN_NO_MIN);
      csr_write(REG_TAN_MAX, '1);
      repeat (6) send_voxel(rand_word(), rand_word());
      drain_voxels();
      write_size(REG_SIZE_X, 3);
      repeat (3) send_voxel(rand_word(), rand_word());
      drain_voxels();
      directed_sent = voxels_sent;

      phases = 0;
      while (voxels_sent - directed_sent < VOXEL_TARGET) begin
         pick_setup();
         if (phases == 6) begin
            // keep offering while the response side is held, so the queue fills
            idle_pct = 0;
            stall_pct  <= 0;
            hold_asked <= hold_asked + 1;
            burst = 150;
         end else begin
            case (phases % 4)
               0: begin idle_pct = 0;  stall_pct <= 0;  end
               1: begin idle_pct = 62; stall_pct <= 0;  end
               2: begin idle_pct = 0;  stall_pct <= 62; end
               default: begin idle_pct = 24; stall_pct <= 24; end
            endcase
            burst = $urandom_range(120, 40);
         end
         repeat (burst) send_voxel(rand_word(), rand_word());
         drain_voxels();
         phases++;
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Summary: %0d voxels, %0d random settings after the directed set,",
               voxels_sent, phases);
      $display("Summary: %0d masked, %0d volume ends, mixed idles and one %0d-cycle hold-off.",
               masked_seen, volumes_seen, LONG_HOLD);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
